// ----- rtl/csct_pkg.sv -----
`default_nettype none
package csct_pkg;

  // defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed port field widths
  localparam int FIELD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int WINDOW_W = 31;
  localparam int COUNT_W  = 2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [COUNT_W-1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } root_count_t;

endpackage
`default_nettype wire

// ----- rtl/csct_ifs.sv -----
`default_nettype none
interface csct_in_if import csct_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  center_ax;
  logic signed [FIELD_W-1:0]  center_ay;
  logic signed [FIELD_W-1:0]  vel_ax;
  logic signed [FIELD_W-1:0]  vel_ay;
  logic        [RADIUS_W-1:0] radius_a;
  logic signed [FIELD_W-1:0]  center_bx;
  logic signed [FIELD_W-1:0]  center_by;
  logic signed [FIELD_W-1:0]  vel_bx;
  logic signed [FIELD_W-1:0]  vel_by;
  logic        [RADIUS_W-1:0] radius_b;

  modport source (
    output valid, center_ax, center_ay, vel_ax, vel_ay, radius_a,
    output center_bx, center_by, vel_bx, vel_by, radius_b,
    input  ready
  );
  modport sink (
    input  valid, center_ax, center_ay, vel_ax, vel_ay, radius_a,
    input  center_bx, center_by, vel_bx, vel_by, radius_b,
    output ready
  );
endinterface

interface csct_out_if import csct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] root_count;
  logic signed [FIELD_W-1:0] t_enter;
  logic signed [FIELD_W-1:0] t_exit;
  logic                      hit;

  modport source (output valid, root_count, t_enter, t_exit, hit, input ready);
  modport sink   (input valid, root_count, t_enter, t_exit, hit, output ready);
endinterface

interface csct_cfg_if import csct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] time_window;

  modport source (output valid, time_window, input ready);
  modport sink   (input valid, time_window, output ready);
endinterface
`default_nettype wire

// ----- rtl/csct_front.sv -----
`default_nettype none
module csct_front import csct_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int DW = CW + 1,
  localparam int ITEM_W = 4 * DW + CW + 1
) (
  csct_in_if.sink           req,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [ITEM_W-1:0] push_data
);

  logic signed [DW-1:0] dx, dy, wx, wy;
  logic        [CW-1:0] rs;
  logic                 azero;

  // relative position and relative velocity, low CW bits of each field
  assign dx = DW'(signed'(req.center_ax[CW-1:0])) - DW'(signed'(req.center_bx[CW-1:0]));
  assign dy = DW'(signed'(req.center_ay[CW-1:0])) - DW'(signed'(req.center_by[CW-1:0]));
  assign wx = DW'(signed'(req.vel_ax[CW-1:0])) - DW'(signed'(req.vel_bx[CW-1:0]));
  assign wy = DW'(signed'(req.vel_ay[CW-1:0])) - DW'(signed'(req.vel_by[CW-1:0]));
  assign rs = CW'(req.radius_a[CW-2:0]) + CW'(req.radius_b[CW-2:0]);

  // equal velocities: leading term is zero, no roots
  assign azero = (wx == '0) && (wy == '0);

  assign push_valid = req.valid;
  assign req.ready  = push_ready;
  assign push_data  = {dx, dy, wx, wy, rs, azero};

endmodule
`default_nettype wire

// ----- rtl/csct_queue.sv -----
`default_nettype none
module csct_queue import csct_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csct_mul.sv -----
`default_nettype none
module csct_mul #(
  parameter int PW = 66,
  localparam int LO = PW / 2,
  localparam int HI = PW - LO
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [PW-1:0] a,
  input  logic signed [PW-1:0] b,
  output logic signed [2*PW-1:0] p
);

  logic signed [HI-1:0]    ah, bh;
  logic signed [LO:0]      al, bl;
  logic signed [2*HI-1:0]  pp_hh;
  logic signed [HI+LO:0]   pp_hl, pp_lh;
  logic        [2*LO-1:0]  pp_ll;

  assign ah = a[PW-1:LO];
  assign bh = b[PW-1:LO];
  assign al = {1'b0, a[LO-1:0]};
  assign bl = {1'b0, b[LO-1:0]};

  // partial products, then the shifted sum
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * bl;
      pp_lh <= al * bh;
      pp_ll <= a[LO-1:0] * b[LO-1:0];
      p <= ((2*PW)'(pp_hh) <<< (2 * LO))
         + (((2*PW)'(pp_hl) + (2*PW)'(pp_lh)) <<< LO)
         + (2*PW)'(pp_ll);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csct_back.sv -----
`default_nettype none
module csct_back import csct_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  localparam int DW = CW + 1,
  localparam int ITEM_W = 4 * DW + CW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [ITEM_W-1:0]   pop_data,
  input  logic [WINDOW_W-1:0] window,
  csct_out_if.source          rsp
);

  localparam int PW   = 2 * DW;        // A, H, C
  localparam int AUW  = PW - 1;        // A magnitude
  localparam int QW   = 2 * PW;        // discriminant
  localparam int SW   = PW;            // root width, one bit per stage
  localparam int RW   = SW + 3;
  localparam int NW0  = PW + 2;        // -H +/- s
  localparam int MAG0 = NW0 - 1;
  localparam int MW   = MAG0 + FB;     // dividend bits, one per stage
  localparam int QTW  = MW + 1;
  localparam logic signed [QTW-1:0] SAT_HI = (QTW'(1) <<< (CW - 1)) - QTW'(1);
  localparam logic signed [QTW-1:0] SAT_LO = ~SAT_HI;

  logic adv;
  assign adv = !rsp.valid || rsp.ready;
  assign pop_ready = adv;

  // unpack
  logic signed [DW-1:0] dx, dy, wx, wy, rse;
  logic        [CW-1:0] rs;
  logic                 az0;
  assign {dx, dy, wx, wy, rs, az0} = pop_data;
  assign rse = DW'(rs);

  // stage 1: products
  logic                 v1, az1;
  logic signed [PW-1:0] p_wxx, p_wyy, p_dxw, p_dyw, p_dxx, p_dyy, p_rr;
  always_ff @(posedge clk) begin
    if (adv) begin
      az1   <= az0;
      p_wxx <= wx * wx;
      p_wyy <= wy * wy;
      p_dxw <= dx * wx;
      p_dyw <= dy * wy;
      p_dxx <= dx * dx;
      p_dyy <= dy * dy;
      p_rr  <= rse * rse;
    end
  end

  // stage 2: quadratic coefficients
  logic                 v2, az2;
  logic signed [PW-1:0] a2, h2, c2;
  always_ff @(posedge clk) begin
    if (adv) begin
      az2 <= az1;
      a2  <= p_wxx + p_wyy;
      h2  <= p_dxw + p_dyw;
      c2  <= p_dxx + p_dyy - p_rr;
    end
  end

  // stages 3 and 4: H*H and A*C
  logic signed [QW-1:0] hh, ac;
  logic                 v3, v4, az3, az4;
  logic signed [PW-1:0] a3, a4, h3, h4;

  csct_mul #(.PW(PW)) u_mul_hh (.clk(clk), .en(adv), .a(h2), .b(h2), .p(hh));
  csct_mul #(.PW(PW)) u_mul_ac (.clk(clk), .en(adv), .a(a2), .b(c2), .p(ac));

  always_ff @(posedge clk) begin
    if (adv) begin
      az3 <= az2;
      az4 <= az3;
      a3  <= a2;
      a4  <= a3;
      h3  <= h2;
      h4  <= h3;
    end
  end

  // square root pipeline, entry filled by the discriminant stage
  logic                 sq_v    [0:SW];
  root_count_t          sq_cnt  [0:SW];
  logic [AUW-1:0]       sq_a    [0:SW];
  logic signed [PW-1:0] sq_h    [0:SW];
  logic [SW:0]          sq_rem  [0:SW];
  logic [SW-1:0]        sq_root [0:SW];
  logic [QW-1:0]        sq_d    [0:SW];

  logic signed [QW-1:0] disc;
  root_count_t          cnt5;
  assign disc = hh - ac;

  always_comb begin
    priority if (az4 || disc[QW-1]) begin
      cnt5 = CNT_NONE;
    end else if (disc == '0) begin
      cnt5 = CNT_ONE;
    end else begin
      cnt5 = CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_cnt[0]  <= cnt5;
      sq_a[0]    <= a4[AUW-1:0];
      sq_h[0]    <= h4;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_d[0]    <= disc;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] x, y, diff;
    logic          ge;
    assign x    = {sq_rem[k], sq_d[k][QW-1 -: 2]};
    assign y    = RW'({sq_root[k], 2'b01});
    assign ge   = x >= y;
    assign diff = x - y;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_cnt[k+1]  <= sq_cnt[k];
        sq_a[k+1]    <= sq_a[k];
        sq_h[k+1]    <= sq_h[k];
        sq_rem[k+1]  <= ge ? diff[SW:0] : x[SW:0];
        sq_root[k+1] <= {sq_root[k][SW-2:0], ge};
        sq_d[k+1]    <= {sq_d[k][QW-3:0], 2'b00};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
  end

  // numerators -H - s and -H + s, as sign and scaled magnitude
  logic signed [NW0-1:0] hx, sx, n1, n2, m1, m2;
  assign hx = NW0'(sq_h[SW]);
  assign sx = NW0'(sq_root[SW]);
  assign n1 = -hx - sx;
  assign n2 = sx - hx;
  assign m1 = n1[NW0-1] ? -n1 : n1;
  assign m2 = n2[NW0-1] ? -n2 : n2;

  // divider pipeline, two lanes sharing the divisor
  logic           dv_v   [0:MW];
  root_count_t    dv_cnt [0:MW];
  logic [AUW-1:0] dv_a   [0:MW];
  logic           dv_n1  [0:MW];
  logic           dv_n2  [0:MW];
  logic [MW-1:0]  dv_m1  [0:MW];
  logic [MW-1:0]  dv_m2  [0:MW];
  logic [AUW-1:0] dv_r1  [0:MW];
  logic [AUW-1:0] dv_r2  [0:MW];
  logic [MW-1:0]  dv_q1  [0:MW];
  logic [MW-1:0]  dv_q2  [0:MW];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_cnt[0] <= sq_cnt[SW];
      dv_a[0]   <= sq_a[SW];
      dv_n1[0]  <= n1[NW0-1];
      dv_n2[0]  <= n2[NW0-1];
      dv_m1[0]  <= {m1[MAG0-1:0], {FB{1'b0}}};
      dv_m2[0]  <= {m2[MAG0-1:0], {FB{1'b0}}};
      dv_r1[0]  <= '0;
      dv_r2[0]  <= '0;
      dv_q1[0]  <= '0;
      dv_q2[0]  <= '0;
    end
  end

  for (genvar j = 0; j < MW; j++) begin : g_div
    logic [AUW:0] x1, x2, ay, d1, d2;
    logic         ge1, ge2;
    assign ay  = {1'b0, dv_a[j]};
    assign x1  = {dv_r1[j], dv_m1[j][MW-1]};
    assign x2  = {dv_r2[j], dv_m2[j][MW-1]};
    assign ge1 = x1 >= ay;
    assign ge2 = x2 >= ay;
    assign d1  = x1 - ay;
    assign d2  = x2 - ay;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_cnt[j+1] <= dv_cnt[j];
        dv_a[j+1]   <= dv_a[j];
        dv_n1[j+1]  <= dv_n1[j];
        dv_n2[j+1]  <= dv_n2[j];
        dv_m1[j+1]  <= {dv_m1[j][MW-2:0], 1'b0};
        dv_m2[j+1]  <= {dv_m2[j][MW-2:0], 1'b0};
        dv_r1[j+1]  <= ge1 ? d1[AUW-1:0] : x1[AUW-1:0];
        dv_r2[j+1]  <= ge2 ? d2[AUW-1:0] : x2[AUW-1:0];
        dv_q1[j+1]  <= {dv_q1[j][MW-2:0], ge1};
        dv_q2[j+1]  <= {dv_q2[j][MW-2:0], ge2};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // floor for negative numerators
  logic signed [QTW-1:0] qs1, qs2, fl1, fl2;
  assign qs1 = QTW'(dv_q1[MW]);
  assign qs2 = QTW'(dv_q2[MW]);
  assign fl1 = dv_n1[MW] ? -qs1 - QTW'(dv_r1[MW] != '0) : qs1;
  assign fl2 = dv_n2[MW] ? -qs2 - QTW'(dv_r2[MW] != '0) : qs2;

  logic                  fin_v;
  root_count_t           fin_cnt;
  logic signed [QTW-1:0] t1, t2;
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_cnt <= dv_cnt[MW];
      t1      <= (dv_cnt[MW] == CNT_NONE) ? '0 : fl1;
      t2      <= (dv_cnt[MW] == CNT_NONE) ? '0 : fl2;
    end
  end

  // hit rule and saturation
  logic signed [QTW-1:0] wins, st1, st2;
  logic                  hit_c;
  assign wins = QTW'(window);
  assign hit_c = ((fin_cnt != CNT_NONE) && (t1 >= 0) && (t1 <= wins))
              || ((fin_cnt == CNT_TWO) && (t1 <= 0) && (t2 >= 0))
              || ((fin_cnt == CNT_TWO) && (t2 >= 0) && (t2 <= wins));
  assign st1 = (t1 > SAT_HI) ? SAT_HI : ((t1 < SAT_LO) ? SAT_LO : t1);
  assign st2 = (t2 > SAT_HI) ? SAT_HI : ((t2 < SAT_LO) ? SAT_LO : t2);

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.root_count <= fin_cnt;
      rsp.t_enter    <= FIELD_W'(signed'(st1[CW-1:0]));
      rsp.t_exit     <= FIELD_W'(signed'(st2[CW-1:0]));
      rsp.hit        <= hit_c;
    end
  end

  // valid chain for the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      sq_v[0]   <= 1'b0;
      dv_v[0]   <= 1'b0;
      fin_v     <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      sq_v[0]   <= v4;
      dv_v[0]   <= sq_v[SW];
      fin_v     <= dv_v[MW];
      rsp.valid <= fin_v;
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.root_count == CNT_NONE) |->
      (rsp.t_enter == '0) && (rsp.t_exit == '0) && !rsp.hit)
    else $error("no-root result carries nonzero times or hit");

  a_tangent_equal: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.root_count == CNT_ONE) |-> rsp.t_enter == rsp.t_exit)
    else $error("tangent result has differing times");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.root_count == CNT_TWO) |-> rsp.t_enter <= rsp.t_exit)
    else $error("entry time after exit time");

  a_count_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.root_count <= CNT_TWO)
    else $error("root count out of range");

endmodule
`default_nettype wire

// ----- rtl/swept_circle_collision_time_top.sv -----
`default_nettype none
// SW = 2*COORD_WIDTH + 2 (one root bit per stage) and MW = SW + 1 + FRAC_BITS
//   (one quotient bit per stage) size the square root and divider pipelines
// throughput: one item per cycle; the back pipeline stalls as a whole only
//   while its output register holds a result that has not been taken
// reset (rst, synchronous): empties queue and pipeline, time_window = 1.0
module swept_circle_collision_time_top import csct_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  csct_in_if.sink    req,
  csct_out_if.source rsp,
  csct_cfg_if.sink   cfg
);

  localparam int ITEM_W = 4 * (COORD_WIDTH + 1) + COORD_WIDTH + 1;

  // hit window register, always writable
  logic [WINDOW_W-1:0] window;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_W'(1) << FRAC_BITS;
    end else if (cfg.valid) begin
      window <= cfg.time_window;
    end
  end

  // front: differences and zero-velocity classification
  logic              push_valid, push_ready;
  logic [ITEM_W-1:0] push_data;

  csct_front #(.CW(COORD_WIDTH)) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // short queue so the front keeps taking items while the back is stalled
  logic              pop_valid, pop_ready;
  logic [ITEM_W-1:0] pop_data;

  csct_queue #(.W(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: coefficients, discriminant, root, two divisions, hit and saturation
  csct_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .window    (window),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
  import csct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  // drain wait at 32 / 16, rounded up from the input-to-result latency
  localparam int LATENCY = 170;
  localparam int WATCHDOG_LIMIT = 5000;

  // wide enough for every intermediate of the contact quadratic
  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [FIELD_W-1:0] center_ax, center_ay, vel_ax, vel_ay;
    logic [RADIUS_W-1:0]       radius_a;
    logic signed [FIELD_W-1:0] center_bx, center_by, vel_bx, vel_by;
    logic [RADIUS_W-1:0]       radius_b;
  } pair_t;

  typedef struct {
    root_count_t               root_count;
    logic signed [FIELD_W-1:0] t_enter;
    logic signed [FIELD_W-1:0] t_exit;
    logic                      hit;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csct_in_if  req ();
  csct_out_if rsp ();
  csct_cfg_if cfg ();

  swept_circle_collision_time_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pair_t          pending_pairs[$];
  contact_t       expected_contacts[$];
  logic [30:0]    window_reg = 31'(ONE);
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             err_count = 0;
  int             quiet_cycles = 0;

  // floor division by a positive divisor
  function automatic wide_t floor_div(wide_t num, wide_t den);
    wide_t q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp_time(wide_t t);
    wide_t hi, lo;
    hi = 192'sd2147483647;
    lo = -192'sd2147483648;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[31:0];
  endfunction

  // solves |d + w t| = ra + rb exactly in wide integers
  function automatic contact_t contact_times(pair_t p, logic [30:0] win);
    wide_t dx, dy, wx, wy, rs, rb, qa, qh, qc, disc, root, cand, t1, t2, winw;
    contact_t r;
    int cnt;
    dx = $signed(p.center_ax) - $signed(p.center_bx);
    dy = $signed(p.center_ay) - $signed(p.center_by);
    wx = $signed(p.vel_ax) - $signed(p.vel_bx);
    wy = $signed(p.vel_ay) - $signed(p.vel_by);
    rs = '0;
    rs[30:0] = p.radius_a;
    rb = '0;
    rb[30:0] = p.radius_b;
    rs = rs + rb;
    winw = '0;
    winw[30:0] = win;
    qa = wx * wx + wy * wy;
    qh = dx * wx + dy * wy;
    qc = dx * dx + dy * dy - rs * rs;
    t1 = '0;
    t2 = '0;
    cnt = 0;
    if (qa != 0) begin
      disc = qh * qh - qa * qc;
      if (disc == 0) begin
        cnt = 1;
        t1 = floor_div((-qh) <<< FRAC, qa);
        t2 = t1;
      end else if (disc > 0) begin
        root = '0;
        for (int i = 70; i >= 0; i--) begin
          cand = root | (wide_t'(1) << i);
          if (cand * cand <= disc) root = cand;
        end
        cnt = 2;
        t1 = floor_div((-qh - root) <<< FRAC, qa);
        t2 = floor_div((-qh + root) <<< FRAC, qa);
      end
    end
    r.hit = 1'b0;
    if (cnt >= 1 && t1 >= 0 && t1 <= winw) r.hit = 1'b1;
    if (cnt == 2 && t1 <= 0 && t2 >= 0) r.hit = 1'b1;
    if (cnt == 2 && t2 >= 0 && t2 <= winw) r.hit = 1'b1;
    r.root_count = (cnt == 0) ? CNT_NONE : (cnt == 1) ? CNT_ONE : CNT_TWO;
    r.t_enter = clamp_time(t1);
    r.t_exit = clamp_time(t2);
    return r;
  endfunction

  function automatic pair_t make_pair(
      int ax, int ay, int vax, int vay, int ra,
      int bx, int by, int vbx, int vby, int rb);
    pair_t p;
    p.center_ax = ax; p.center_ay = ay; p.vel_ax = vax; p.vel_ay = vay;
    p.radius_a = 31'(ra);
    p.center_bx = bx; p.center_by = by; p.vel_bx = vbx; p.vel_by = vby;
    p.radius_b = 31'(rb);
    return p;
  endfunction

  // small signed value in Q16.16, up to +-range units
  function automatic int near_val(int range);
    return $urandom_range(2 * range * 65536) - range * 65536;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(99);
    if (mode < 20) begin
      // full range, every bit random
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      // nearby circles whose contact times cluster around the window
      p = make_pair(near_val(8), near_val(8), near_val(4), near_val(4),
                    $urandom_range(2 * 65536),
                    near_val(8), near_val(8), near_val(4), near_val(4),
                    $urandom_range(2 * 65536));
      if (mode < 28) begin
        // same velocity: no relative motion
        p.vel_bx = p.vel_ax;
        p.vel_by = p.vel_ay;
      end else if (mode < 34) begin
        // one axis only, to hit exact tangents and whole times more often
        p.center_ay = p.center_by;
        p.vel_ay = p.vel_by;
      end
    end
    return p;
  endfunction

  // driver: one nonblocking write of valid per edge
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready)
        expected_contacts.push_back(contact_times(pair_t'{
          req.center_ax, req.center_ay, req.vel_ax, req.vel_ay, req.radius_a,
          req.center_bx, req.center_by, req.vel_bx, req.vel_by, req.radius_b},
          window_reg));
      if (!req.valid || req.ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          req.center_ax <= p.center_ax;
          req.center_ay <= p.center_ay;
          req.vel_ax <= p.vel_ax;
          req.vel_ay <= p.vel_ay;
          req.radius_a <= p.radius_a;
          req.center_bx <= p.center_bx;
          req.center_by <= p.center_by;
          req.vel_bx <= p.vel_bx;
          req.vel_by <= p.vel_by;
          req.radius_b <= p.radius_b;
          req.valid <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, field by field compare against oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_contacts.size() == 0) begin
          $error("result transfer with no prediction waiting");
          err_count++;
        end else begin
          contact_t e;
          e = expected_contacts.pop_front();
          if (rsp.root_count !== e.root_count) begin
            $error("root_count expected %0d actual %0d", e.root_count, rsp.root_count);
            err_count++;
          end
          if (rsp.t_enter !== e.t_enter) begin
            $error("t_enter expected %0d actual %0d", e.t_enter, rsp.t_enter);
            err_count++;
          end
          if (rsp.t_exit !== e.t_exit) begin
            $error("t_exit expected %0d actual %0d", e.t_exit, rsp.t_exit);
            err_count++;
          end
          if (rsp.hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, rsp.hit);
            err_count++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // wait until every prediction has been checked and the pipeline has drained
  task automatic drain_block();
    wait (pending_pairs.size() == 0 && !req.valid && expected_contacts.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_window(logic [30:0] w);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.time_window <= w;
    do @(posedge clk); while (!cfg.ready);
    window_reg = w;
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [30:0] windows[6];
    req.valid = 1'b0;
    req.center_ax = '0; req.center_ay = '0; req.vel_ax = '0; req.vel_ay = '0;
    req.radius_a = '0;
    req.center_bx = '0; req.center_by = '0; req.vel_bx = '0; req.vel_by = '0;
    req.radius_b = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.time_window = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset window of 1.0
    // extremes of every field
    pending_pairs.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h7fffffff));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, 32'h7fffffff,
      -1, -1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    // equal velocities while overlapping: still no roots
    pending_pairs.push_back(make_pair(0, 0, ONE, ONE, 2 * ONE, ONE, 0, ONE, ONE, 2 * ONE));
    // tangent graze at t = 10
    pending_pairs.push_back(make_pair(0, 0, ONE, 0, ONE, 10 * ONE, 2 * ONE, 0, 0, ONE));
    // tangent graze at t = 0.5, inside the window
    pending_pairs.push_back(make_pair(0, 0, 2 * ONE, 0, ONE, ONE, 2 * ONE, 0, 0, ONE));
    // miss: negative discriminant
    pending_pairs.push_back(make_pair(0, 0, ONE, 0, ONE, 5 * ONE, 5 * ONE, 0, 0, ONE));
    // entry inside the window
    pending_pairs.push_back(make_pair(0, 0, 4 * ONE, 0, ONE, 3 * ONE, 0, 0, 0, ONE));
    // already overlapping: entry before zero, exit after
    pending_pairs.push_back(make_pair(0, 0, ONE, 0, ONE, ONE / 2, 0, 0, 0, ONE));
    // entry and exit both after the window
    pending_pairs.push_back(make_pair(0, 0, ONE, 0, ONE, 20 * ONE, 0, 0, 0, ONE));
    // both contacts in the past
    pending_pairs.push_back(make_pair(0, 0, ONE, 0, ONE, -20 * ONE, 0, 0, 0, ONE));
    // exit inside window only (entry in the past, moving apart)
    pending_pairs.push_back(make_pair(0, 0, -ONE, 0, ONE, ONE, 0, 0, 0, ONE));
    // receding, moving along y, distant
    pending_pairs.push_back(make_pair(0, 0, 0, -3 * ONE, 0, 0, 7 * ONE, 0, 0, ONE));
    // negative time with a fractional quotient, exercises floor rounding
    pending_pairs.push_back(make_pair(0, 0, 3 * ONE, ONE, ONE, -7 * ONE, 1, 0, 0, 1));
    // tiny relative velocity, times saturate
    pending_pairs.push_back(make_pair(0, 0, 1, 0, ONE, 32'h40000000, 0, 0, 0, ONE));
    pending_pairs.push_back(make_pair(0, 0, -1, 0, ONE, 32'h40000000, 0, 0, 0, ONE));
    drain_block();

    // random part over several window settings, extremes included
    windows[0] = 31'(ONE);
    windows[1] = '0;
    windows[2] = 31'h7fffffff;
    windows[3] = 31'(ONE / 4);
    windows[4] = 31'($urandom);
    windows[5] = 31'($urandom_range(8 * ONE));
    for (int ph = 0; ph < 6; ph++) begin
      write_window(windows[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 165; n++) pending_pairs.push_back(random_pair());
      drain_block();
    end

    if (expected_contacts.size() != 0) begin
      $error("%0d predictions never matched by a result", expected_contacts.size());
      err_count++;
    end
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ----- swept_circle_collision_time_top.f -----
rtl/csct_pkg.sv
rtl/csct_ifs.sv
rtl/csct_front.sv
rtl/csct_queue.sv
rtl/csct_mul.sv
rtl/csct_back.sv
rtl/swept_circle_collision_time_top.sv
verif/tb.sv
